### sv/lvfc_pkg.sv
// ----------------------------------------------------------------------------
// lvfc_pkg
// Shared types and constants for the latest-value frame coalescer.
// ----------------------------------------------------------------------------
package lvfc_pkg;

	localparam int ID_W      = 11;
	localparam int WORD_W    = 32;
	localparam int CNT_W     = 32;
	localparam int LEN_W     = 11;
	localparam int MAX_SLOTS = 6;
	localparam int DEF_SLOTS = 6;

	// config register indexes
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = ID_W;
	localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_ID = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOT_ID_0  = 3'd1;

	// command codes
	localparam logic CMD_PACKET = 1'b0;
	localparam logic CMD_TICK   = 1'b1;

	localparam logic [LEN_W-1:0] MIN_PACKET_LEN = 11'd13;
	localparam logic [7:0]       TRIG_BYTE_ZERO = 8'd0;

	localparam logic [ID_W-1:0] TRIGGER_ID_RST = 11'h7F0;
	localparam logic [ID_W-1:0] SLOT_ID_RST [MAX_SLOTS] = '{
		11'h150, 11'h151, 11'h155, 11'h156, 11'h157, 11'h471
	};

	typedef struct packed {
		logic              command;
		logic [LEN_W-1:0]  packet_length;
		logic [WORD_W-1:0] header_word;
		logic [WORD_W-1:0] payload_lo;
		logic [WORD_W-1:0] payload_hi;
	} cmd_t;

	typedef struct packed {
		logic              frame_valid;
		logic [ID_W-1:0]   frame_id;
		logic [WORD_W-1:0] frame_lo;
		logic [WORD_W-1:0] frame_hi;
		logic              toggle_bit;
		logic              soft_trigger;
		logic [CNT_W-1:0]  received_count;
		logic [CNT_W-1:0]  sent_count;
		logic [CNT_W-1:0]  dropped_count;
	} res_t;

endpackage

### sv/latest_value_frame_coalescer.sv
// ----------------------------------------------------------------------------
// latest_value_frame_coalescer
// Keeps the latest payload per forwarded id and emits one pending slot per
// pacing tick, round-robin, with packet/drop/send counters.
// ----------------------------------------------------------------------------
//
//  port group  | dir | handshake            | word
//  ------------+-----+----------------------+------------------------------
//  cmd         | in  | cmd_valid/cmd_ready  | packet or tick (lvfc_pkg::cmd_t)
//  res         | out | res_valid/res_ready  | one result per cmd (res_t)
//  cfg         | in  | cfg_we (no wait)     | trigger id, slot ids 0..5
//
//  - One word per cycle sustained while res_ready is high, through the
//    input reg _s1 then the result reg. The state loop is the slot match / RR pick.
//  - Every accepted word produces exactly one result word.
//  - A stalled result holds the result reg; the _s1 stage still drains into
//    it as soon as res_ready frees it, and cmd_ready drops only when both
//    stages are full.
//  - arst_n clears control state, counters, pending bits and the config regs
//    to their defaults; slot payload regs are not reset (only read when
//    pending, which requires a prior write).
//
module latest_value_frame_coalescer #(
	parameter int SLOTS = lvfc_pkg::DEF_SLOTS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [lvfc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lvfc_pkg::CFG_W-1:0]     cfg_data,
	input  logic                           cmd_valid,
	output logic                           cmd_ready,
	input  lvfc_pkg::cmd_t                 cmd,
	output logic                           res_valid,
	input  logic                           res_ready,
	output lvfc_pkg::res_t                 res
);
	import lvfc_pkg::*;

	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [IDX_W:0] SLOTS_X = (IDX_W+1)'(SLOTS);

	// config regs: all six slot ids are stored, only SLOTS take part
	logic [ID_W-1:0]   trigger_id_q;
	logic [ID_W-1:0]   slot_id_q [MAX_SLOTS];

	// slot state
	logic [WORD_W-1:0] slot_lo_q [SLOTS];
	logic [WORD_W-1:0] slot_hi_q [SLOTS];
	logic [SLOTS-1:0]  pending_q;
	logic [IDX_W-1:0]  ptr_q;
	logic              toggle_q;
	logic              trig_q;
	logic [CNT_W-1:0]  rx_cnt_q;
	logic [CNT_W-1:0]  tx_cnt_q;
	logic [CNT_W-1:0]  drop_cnt_q;

	// pipeline
	logic   valid_s1;
	cmd_t   cmd_s1;
	logic   res_valid_q;
	res_t   res_q;
	logic   advance;

	// next-state
	logic              is_tick;
	logic              is_short;
	logic              trig_hit;
	logic [ID_W-1:0]   pkt_id;
	logic              slot_hit;
	logic [IDX_W-1:0]  hit_idx;
	logic              found;
	logic [IDX_W-1:0]  pick_idx;
	logic [IDX_W:0]    ptr_nxt;
	res_t              res_nxt;

	// item moves from _s1 into the result reg when that reg is free or draining
	assign advance   = valid_s1 && (!res_valid_q || res_ready);
	assign cmd_ready = !valid_s1 || advance;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// ---------------- config ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trigger_id_q <= TRIGGER_ID_RST;
			for (int s = 0; s < MAX_SLOTS; s++) begin
				slot_id_q[s] <= SLOT_ID_RST[s];
			end
		end else if (cfg_we) begin
			if (cfg_index == CFG_TRIGGER_ID) begin
				trigger_id_q <= cfg_data;
			end
			for (int s = 0; s < MAX_SLOTS; s++) begin
				if (cfg_index == CFG_IDX_W'(int'(CFG_SLOT_ID_0) + s)) begin
					slot_id_q[s] <= cfg_data;
				end
			end
		end
	end

	// ---------------- decode of the _s1 word ----------------
	assign is_tick  = (cmd_s1.command == CMD_TICK);
	assign pkt_id   = cmd_s1.header_word[ID_W-1:0];
	assign is_short = (cmd_s1.packet_length < MIN_PACKET_LEN);
	assign trig_hit = (pkt_id == trigger_id_q);

	// first matching slot wins
	always_comb begin
		slot_hit = 1'b0;
		hit_idx  = '0;
		for (int s = SLOTS - 1; s >= 0; s--) begin
			if (slot_id_q[s] == pkt_id) begin
				slot_hit = 1'b1;
				hit_idx  = IDX_W'(s);
			end
		end
	end

	// round-robin pick: first pending slot at or after ptr_q, wrapping
	always_comb begin
		logic [IDX_W:0] cand;
		found    = 1'b0;
		pick_idx = '0;
		cand     = '0;
		for (int k = 0; k < SLOTS; k++) begin
			cand = {1'b0, ptr_q} + (IDX_W+1)'(k);
			if (cand >= SLOTS_X) begin
				cand = cand - SLOTS_X;
			end
			if (!found && pending_q[cand[IDX_W-1:0]]) begin
				found    = 1'b1;
				pick_idx = cand[IDX_W-1:0];
			end
		end
		ptr_nxt = {1'b0, pick_idx} + (IDX_W+1)'(1);
		if (ptr_nxt == SLOTS_X) begin
			ptr_nxt = '0;
		end
	end

	// ---------------- result word ----------------
	always_comb begin
		res_nxt                = '0;
		res_nxt.toggle_bit     = toggle_q;
		res_nxt.soft_trigger   = trig_q;
		res_nxt.received_count = rx_cnt_q;
		res_nxt.sent_count     = tx_cnt_q;
		res_nxt.dropped_count  = drop_cnt_q;
		if (is_tick) begin
			if (found) begin
				res_nxt.frame_valid = 1'b1;
				res_nxt.frame_id    = slot_id_q[pick_idx];
				res_nxt.frame_lo    = slot_lo_q[pick_idx];
				res_nxt.frame_hi    = slot_hi_q[pick_idx];
				res_nxt.toggle_bit  = !toggle_q;
				res_nxt.sent_count  = tx_cnt_q + CNT_W'(1);
			end
		end else begin
			res_nxt.received_count = rx_cnt_q + CNT_W'(1);
			if (is_short) begin
				res_nxt.dropped_count = drop_cnt_q + CNT_W'(1);
			end else if (trig_hit) begin
				res_nxt.soft_trigger = (cmd_s1.payload_lo[7:0] != TRIG_BYTE_ZERO);
			end
		end
	end

	// ---------------- pipeline regs ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd_ready) begin
				valid_s1 <= cmd_valid;
			end
			if (advance) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_ready && cmd_valid) begin
			cmd_s1 <= cmd;
		end
		if (advance) begin
			res_q <= res_nxt;
		end
	end

	// ---------------- block state ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q  <= '0;
			ptr_q      <= '0;
			toggle_q   <= 1'b0;
			trig_q     <= 1'b0;
			rx_cnt_q   <= '0;
			tx_cnt_q   <= '0;
			drop_cnt_q <= '0;
		end else if (advance) begin
			toggle_q   <= res_nxt.toggle_bit;
			trig_q     <= res_nxt.soft_trigger;
			rx_cnt_q   <= res_nxt.received_count;
			tx_cnt_q   <= res_nxt.sent_count;
			drop_cnt_q <= res_nxt.dropped_count;
			if (is_tick) begin
				if (found) begin
					pending_q[pick_idx] <= 1'b0;
					ptr_q               <= ptr_nxt[IDX_W-1:0];
				end
			end else if (!is_short && !trig_hit && slot_hit) begin
				pending_q[hit_idx] <= 1'b1;
			end
		end
	end

	// slot payloads, no reset
	always_ff @(posedge clk) begin
		if (advance && !is_tick && !is_short && !trig_hit && slot_hit) begin
			slot_lo_q[hit_idx] <= cmd_s1.payload_lo;
			slot_hi_q[hit_idx] <= cmd_s1.payload_hi;
		end
	end

endmodule

### sv/lvfc_checker.sv
// ----------------------------------------------------------------------------
// lvfc_checker
// Port-level checks for the coalescer, bound to the top level.
// ----------------------------------------------------------------------------
module lvfc_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           res_valid,
	input logic           res_ready,
	input lvfc_pkg::res_t res
);
	import lvfc_pkg::*;

	logic             have_prev_q;
	logic [CNT_W-1:0] prev_rx_q;
	logic [CNT_W-1:0] prev_tx_q;
	logic             prev_toggle_q;
	logic             res_take;

	assign res_take = res_valid && res_ready;

	// last delivered result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_prev_q   <= 1'b0;
			prev_rx_q     <= '0;
			prev_tx_q     <= '0;
			prev_toggle_q <= 1'b0;
		end else if (res_take) begin
			have_prev_q   <= 1'b1;
			prev_rx_q     <= res.received_count;
			prev_tx_q     <= res.sent_count;
			prev_toggle_q <= res.toggle_bit;
		end
	end

	// stalled result word holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result word changed while stalled");

	// no emission means zeroed frame fields
	a_idle_frame_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.frame_valid |->
			res.frame_id == '0 && res.frame_lo == '0 && res.frame_hi == '0)
		else $error("frame fields nonzero without emission");

	// sent count and toggle step exactly with emissions
	a_sent_toggle: assert property (@(posedge clk) disable iff (!arst_n)
		res_take && have_prev_q |->
			res.sent_count == prev_tx_q + CNT_W'(res.frame_valid) &&
			res.toggle_bit == (prev_toggle_q ^ res.frame_valid))
		else $error("sent count or toggle out of step");

	// each word is a packet or a tick, never both
	a_rx_step: assert property (@(posedge clk) disable iff (!arst_n)
		res_take && have_prev_q |->
			(res.received_count == prev_rx_q ||
			 (res.received_count == prev_rx_q + CNT_W'(1) && !res.frame_valid)))
		else $error("received count out of step");

endmodule

bind latest_value_frame_coalescer lvfc_checker u_lvfc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res_valid),
	.res_ready (res_ready),
	.res       (res)
);

### tb/latest_value_frame_coalescer_tb.sv
// ----------------------------------------------------------------------------
// latest_value_frame_coalescer_tb
// Self-checking bench for the frame coalescer. A driver sends packet and tick
// words with random gaps, a monitor checks every result word against an
// in-bench prediction, and the slot/trigger ids are reloaded between phases.
// ----------------------------------------------------------------------------
module latest_value_frame_coalescer_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import lvfc_pkg::*;

	localparam int NSLOTS     = DEF_SLOTS;
	localparam int NREGS      = 1 + MAX_SLOTS;
	localparam int PHASES     = 6;
	localparam int PHASE_LEN  = 140;
	localparam int QUIET_MAX  = 2000;

	// one queued input word plus its pacing
	typedef struct {
		cmd_t        word;
		int unsigned gap;    // idle cycles before the word is offered
		bit          drain;  // hold off until every result is back
	} send_t;

	logic clk;
	logic arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic cmd_valid;
	logic cmd_ready;
	cmd_t cmd_word;
	logic res_valid;
	logic res_ready;
	res_t res_word;

	latest_value_frame_coalescer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd_word),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res_word)
	);

	// ------------------------------------------------------------------
	// Predicted block state: id registers, held payloads, counters.
	// ------------------------------------------------------------------
	logic [ID_W-1:0]   trig_id_reg;
	logic [ID_W-1:0]   slot_id_reg [MAX_SLOTS];
	logic [WORD_W-1:0] held_lo     [MAX_SLOTS];
	logic [WORD_W-1:0] held_hi     [MAX_SLOTS];
	bit                held_dirty  [MAX_SLOTS];
	int                next_scan;
	logic              tog_state;
	logic              trig_state;
	logic [CNT_W-1:0]  n_rx;
	logic [CNT_W-1:0]  n_tx;
	logic [CNT_W-1:0]  n_drop;

	send_t words_to_send [$];
	res_t  frames_due    [$];

	int          mismatches;
	int          tx_mode;      // 0: no gaps, 1: heavy gaps, 2: occasional gaps
	int          rx_mode;
	int unsigned send_wait;
	bit          cmd_taken;
	int unsigned stall_left;
	int unsigned quiet;
	res_t        want_word;
	logic [ID_W-1:0] cfg_vals [NREGS];
	cmd_t        dir_word;

	// Apply one accepted word to the predicted state and return the result
	// word the block owes for it.
	function automatic res_t next_frame_result(cmd_t c);
		res_t            r;
		logic [ID_W-1:0] id;
		int              k;
		int              idx;
		bit              hit;
		r   = '0;
		id  = c.header_word[ID_W-1:0];
		hit = 0;
		if (c.command == CMD_PACKET) begin
			n_rx = n_rx + 1'b1;
			if (c.packet_length < MIN_PACKET_LEN) begin
				n_drop = n_drop + 1'b1;
			end else if (id == trig_id_reg) begin
				// trigger id never forwards, even if a slot shares it
				trig_state = (c.payload_lo[7:0] != TRIG_BYTE_ZERO);
			end else begin
				// lowest matching slot takes the payload
				for (k = 0; k < NSLOTS; k++) begin
					if (!hit && slot_id_reg[k] == id) begin
						held_lo[k]    = c.payload_lo;
						held_hi[k]    = c.payload_hi;
						held_dirty[k] = 1;
						hit = 1;
					end
				end
			end
		end else begin
			// round-robin scan from the slot after the last one sent
			for (k = 0; k < NSLOTS; k++) begin
				idx = (next_scan + k) % NSLOTS;
				if (!hit && held_dirty[idx]) begin
					held_dirty[idx] = 0;
					tog_state  = ~tog_state;
					n_tx       = n_tx + 1'b1;
					next_scan  = (idx + 1) % NSLOTS;
					r.frame_valid = 1'b1;
					r.frame_id    = slot_id_reg[idx];
					r.frame_lo    = held_lo[idx];
					r.frame_hi    = held_hi[idx];
					hit = 1;
				end
			end
		end
		r.toggle_bit     = tog_state;
		r.soft_trigger   = trig_state;
		r.received_count = n_rx;
		r.sent_count     = n_tx;
		r.dropped_count  = n_drop;
		return r;
	endfunction

	function automatic int unsigned draw_wait(int mode);
		case (mode)
			0: return 0;
			1: return $urandom_range(0, 15);
			default: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0;
		endcase
	endfunction

	function automatic cmd_t packet(logic [LEN_W-1:0] len, logic [ID_W-1:0] id,
			logic [WORD_W-1:0] lo, logic [WORD_W-1:0] hi);
		cmd_t w;
		w.command       = CMD_PACKET;
		w.packet_length = len;
		w.header_word   = $urandom;
		w.header_word[ID_W-1:0] = id;
		w.payload_lo    = lo;
		w.payload_hi    = hi;
		return w;
	endfunction

	// Random word: mostly packets aimed at live slot ids, with ticks mixed
	// in so that slots keep getting filled and drained.
	function automatic cmd_t random_word(bit force_tick);
		cmd_t            w;
		logic [ID_W-1:0] id;
		int              pick;
		w.command       = (force_tick || $urandom_range(0, 99) < 35) ? CMD_TICK : CMD_PACKET;
		w.packet_length = LEN_W'($urandom);
		w.header_word   = $urandom;
		w.payload_lo    = $urandom;
		w.payload_hi    = $urandom;
		if (w.command == CMD_PACKET) begin
			w.packet_length = LEN_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 12)
				: $urandom_range(13, 2047));
			pick = $urandom_range(0, 9);
			if (pick <= 5)
				id = slot_id_reg[$urandom_range(0, NSLOTS - 1)];
			else if (pick == 6)
				id = trig_id_reg;
			else
				id = ID_W'($urandom_range(0, 2047));
			w.header_word[ID_W-1:0] = id;
			if (id == trig_id_reg && $urandom_range(0, 1) == 0)
				w.payload_lo[7:0] = 8'h00;
		end
		return w;
	endfunction

	task automatic push_word(cmd_t w, bit drain);
		send_t s;
		s.word  = w;
		s.gap   = draw_wait(tx_mode);
		s.drain = drain;
		words_to_send.push_back(s);
	endtask

	// Block is idle once nothing is queued, offered or owed.
	task automatic wait_idle();
		while (words_to_send.size() != 0 || cmd_valid || frames_due.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Write all id registers; the prediction follows at the same time since
	// the block is idle.
	task automatic load_config();
		int i;
		for (i = 0; i < NREGS; i++) begin
			@(negedge clk);
			cfg_we    <= 1'b1;
			cfg_index <= (i == 0) ? CFG_TRIGGER_ID : CFG_SLOT_ID_0 + CFG_IDX_W'(i - 1);
			cfg_data  <= cfg_vals[i];
			if (i == 0)
				trig_id_reg = cfg_vals[i];
			else
				slot_id_reg[i - 1] = cfg_vals[i];
		end
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic void check_field(string name, logic [WORD_W-1:0] want,
			logic [WORD_W-1:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s expected %h actual %h", $time, name, want, got);
		end
	endfunction

	// ------------------------------------------------------------------
	// Clock
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Driver: accepts on the rising edge, presents the next word on the
	// falling edge. A word stays up, unchanged, until it is taken.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		cmd_taken <= cmd_valid && cmd_ready;
		if (arst_n && cmd_valid && cmd_ready)
			frames_due.push_back(next_frame_result(cmd_word));
	end

	always @(negedge clk) begin
		if (arst_n && (!cmd_valid || cmd_taken)) begin
			if (words_to_send.size() == 0) begin
				cmd_valid <= 1'b0;
			end else if (words_to_send[0].drain && frames_due.size() != 0) begin
				// hold back until the block has returned everything
				cmd_valid <= 1'b0;
			end else if (send_wait < words_to_send[0].gap) begin
				send_wait <= send_wait + 1;
				cmd_valid <= 1'b0;
			end else begin
				cmd_word  <= words_to_send[0].word;
				cmd_valid <= 1'b1;
				send_wait <= 0;
				void'(words_to_send.pop_front());
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: checks each result word against the oldest expectation and
	// draws a fresh stall after each one.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready) begin
			stall_left <= draw_wait(rx_mode);
			if (frames_due.size() == 0) begin
				mismatches++;
				$display("%0t: result word with nothing expected, actual %h", $time, res_word);
			end else begin
				want_word = frames_due.pop_front();
				check_field("frame_valid",    want_word.frame_valid,    res_word.frame_valid);
				check_field("frame_id",       want_word.frame_id,       res_word.frame_id);
				check_field("frame_lo",       want_word.frame_lo,       res_word.frame_lo);
				check_field("frame_hi",       want_word.frame_hi,       res_word.frame_hi);
				check_field("toggle_bit",     want_word.toggle_bit,     res_word.toggle_bit);
				check_field("soft_trigger",   want_word.soft_trigger,   res_word.soft_trigger);
				check_field("received_count", want_word.received_count, res_word.received_count);
				check_field("sent_count",     want_word.sent_count,     res_word.sent_count);
				check_field("dropped_count",  want_word.dropped_count,  res_word.dropped_count);
			end
		end
	end

	always @(negedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			res_ready  <= 1'b0;
		end else begin
			res_ready <= arst_n;
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: too long without any word moving ends the run.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if ((cmd_valid && cmd_ready) || (res_valid && res_ready)) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
			if (quiet >= QUIET_MAX) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	initial begin
		arst_n     = 1'b0;
		cfg_we     = 1'b0;
		cfg_index  = CFG_TRIGGER_ID;
		cfg_data   = '0;
		cmd_valid  = 1'b0;
		cmd_word   = '0;
		res_ready  = 1'b0;
		cmd_taken  = 1'b0;
		send_wait  = 0;
		stall_left = 0;
		quiet      = 0;
		mismatches = 0;
		tx_mode    = 2;
		rx_mode    = 2;

		// prediction starts from the reset state
		trig_id_reg = TRIGGER_ID_RST;
		for (int i = 0; i < MAX_SLOTS; i++) begin
			slot_id_reg[i] = SLOT_ID_RST[i];
			held_lo[i]     = '0;
			held_hi[i]     = '0;
			held_dirty[i]  = 0;
		end
		next_scan  = 0;
		tog_state  = 1'b0;
		trig_state = 1'b0;
		n_rx       = '0;
		n_tx       = '0;
		n_drop     = '0;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part under the reset ids.
		push_word(random_word(1), 0);                                       // tick, nothing held
		push_word(packet(11'd0,  SLOT_ID_RST[0], $urandom, $urandom), 0);   // empty packet drops
		push_word(packet(11'd12, TRIGGER_ID_RST, 32'hFF, $urandom), 0);     // one byte short
		push_word(packet(11'd13, SLOT_ID_RST[0], '1, '1), 0);               // shortest kept
		push_word(packet(11'd2047, SLOT_ID_RST[1], '0, '0), 0);             // longest
		push_word(packet(11'd20, TRIGGER_ID_RST, 32'h0000_0001, $urandom), 0); // trigger on
		push_word(packet(11'd20, TRIGGER_ID_RST, 32'hFFFF_FF00, $urandom), 0); // off: low payload byte zero
		push_word(packet(11'd20, TRIGGER_ID_RST, 32'h0000_00FF, $urandom), 0);
		push_word(packet(11'd40, SLOT_ID_RST[2], $urandom, $urandom), 0);
		push_word(packet(11'd40, SLOT_ID_RST[2], $urandom, $urandom), 0);   // latest value wins
		push_word(packet(11'd40, SLOT_ID_RST[3], $urandom, $urandom), 0);
		push_word(packet(11'd40, SLOT_ID_RST[4], $urandom, $urandom), 0);
		push_word(packet(11'd40, SLOT_ID_RST[5], $urandom, $urandom), 0);
		dir_word = packet(11'd30, 11'h7FF, $urandom, $urandom);
		dir_word.header_word = '1;                                          // no slot matches
		push_word(dir_word, 0);
		dir_word = packet(11'd30, 11'h000, $urandom, $urandom);
		dir_word.header_word = '0;
		push_word(dir_word, 0);
		// drain all six slots, then one tick with nothing left
		for (int i = 0; i < 7; i++)
			push_word(random_word(1), i == 0);
		push_word(packet(11'd50, SLOT_ID_RST[4], $urandom, $urandom), 0);
		push_word(packet(11'd50, SLOT_ID_RST[1], $urandom, $urandom), 0);
		push_word(random_word(1), 0);
		wait_idle();

		// Random phases, each under its own id setting and pacing.
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: cfg_vals = '{11'h000, 11'h7FF, 11'h7FF, 11'h001, 11'h000, 11'h400, 11'h2AA};
				1: cfg_vals = '{11'h7FF, 11'h000, 11'h001, 11'h002, 11'h003, 11'h004, 11'h7FF};
				4: begin
					// tiny id range: lots of duplicate slot ids
					for (int i = 0; i < NREGS; i++)
						cfg_vals[i] = ID_W'($urandom_range(0, 3));
				end
				5: begin
					cfg_vals[0] = TRIGGER_ID_RST;
					for (int i = 0; i < MAX_SLOTS; i++)
						cfg_vals[i + 1] = SLOT_ID_RST[i];
				end
				default: begin
					for (int i = 0; i < NREGS; i++)
						cfg_vals[i] = ID_W'($urandom_range(0, 2047));
				end
			endcase
			load_config();
			tx_mode = p % 3;
			rx_mode = (p + 1) % 3;
			for (int n = 0; n < PHASE_LEN; n++)
				push_word(random_word(0), n == PHASE_LEN / 2 || $urandom_range(0, 49) == 0);
			wait_idle();
		end

		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
